// ===== sv/ntd_pkg.sv =====
`timescale 1ns / 1ps
// ntd_pkg: shared constants, codes and control types of nearest_trait_distance
// depends on nothing
package ntd_pkg;

   localparam int VALUE_BITS = 24;
   localparam int DIST_BITS  = 50;
   localparam int MAX_TRAITS = 16;
   localparam int MAX_DIMS   = 4;
   localparam int SLOT_BITS  = 4;
   localparam int DIM_BITS   = 2;
   localparam int COUNT_BITS = 5;
   localparam int NDIM_BITS  = 3;
   localparam int DIFF_BITS  = VALUE_BITS + 2;
   localparam int SQ_BITS    = 2 * DIFF_BITS;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [2:0] KIND_POINT     = 3'd0;
   localparam logic [2:0] KIND_NDPOINT   = 3'd1;
   localparam logic [2:0] KIND_INTERVAL  = 3'd2;
   localparam logic [2:0] KIND_RECTANGLE = 3'd3;
   localparam logic [2:0] KIND_HYPERBOX  = 3'd4;

   localparam logic REG_TRAIT_COUNT = 1'b0;
   localparam logic REG_DIMS_IN_USE = 1'b1;

   typedef struct packed {
      logic                 write_trait;
      logic                 load_sample;
      logic                 trait_init;
      logic                 mem_read;
      logic                 eval;
      logic                 square;
      logic                 accum;
      logic                 compare;
      logic                 finish;
      logic [SLOT_BITS-1:0] trait;
      logic [DIM_BITS-1:0]  dim;
   } ntd_cmd_type;

   typedef struct packed {
      logic                 kind_ok;
      logic [NDIM_BITS-1:0] dims;
      logic                 rsp_busy;
   } ntd_status_type;

endpackage

// ===== sv/ntd_datapath.sv =====
`timescale 1ns / 1ps
// ntd_datapath: trait tables, per-dimension distance unit, minimum search and result word
// depends on ntd_pkg; driven by ntd_controller commands
module ntd_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ntd_pkg::ntd_cmd_type                   cmd,
   output ntd_pkg::ntd_status_type                status,
   input  logic [ntd_pkg::NDIM_BITS-1:0]          dims_num,
   input  logic [ntd_pkg::SLOT_BITS-1:0]          req_slot,
   input  logic [2:0]                             req_kind,
   input  logic [7:0]                             req_color_index,
   input  logic [ntd_pkg::DIM_BITS-1:0]           req_dim_sel,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0]  req_bound_low,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0]  req_bound_high,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0]  req_sample_0,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0]  req_sample_1,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0]  req_sample_2,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0]  req_sample_3,
   input  logic                                   req_start_of_frame,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ntd_pkg::DIST_BITS-1:0]          rsp_min_distance,
   output logic [ntd_pkg::SLOT_BITS-1:0]          rsp_nearest_slot,
   output logic [7:0]                             rsp_nearest_color,
   output logic [ntd_pkg::DIST_BITS-1:0]          rsp_running_max
);

   localparam int VB = ntd_pkg::VALUE_BITS;
   localparam int DB = ntd_pkg::DIST_BITS;
   localparam int FB = ntd_pkg::DIFF_BITS;
   localparam int ADDR_BITS = ntd_pkg::SLOT_BITS + ntd_pkg::DIM_BITS;

   logic [2:0]           kind_mem [ntd_pkg::MAX_TRAITS];
   logic [7:0]           color_mem [ntd_pkg::MAX_TRAITS];
   logic signed [VB-1:0] low_mem [ntd_pkg::MAX_TRAITS * ntd_pkg::MAX_DIMS];
   logic signed [VB-1:0] high_mem [ntd_pkg::MAX_TRAITS * ntd_pkg::MAX_DIMS];

   logic signed [VB-1:0] sample_ff [ntd_pkg::MAX_DIMS];
   logic                 sof_ff;
   logic signed [VB-1:0] low_rd_ff, high_rd_ff;
   logic [FB-1:0]        diff_ff;
   logic                 outside_ff;
   logic [ntd_pkg::SQ_BITS-1:0] sq_ff;
   logic [DB-1:0]        acc_ff, acc_in;
   logic                 trait_out_ff;
   logic [DB-1:0]        best_ff;
   logic                 found_ff;
   logic [ntd_pkg::SLOT_BITS-1:0] best_slot_ff;
   logic [7:0]           best_color_ff;
   logic [DB-1:0]        max_seen_ff;
   logic                 rsp_valid_ff;
   logic [DB-1:0]        rsp_dist_ff, rsp_max_ff;
   logic [ntd_pkg::SLOT_BITS-1:0] rsp_slot_ff;
   logic [7:0]           rsp_color_ff;

   logic [2:0]           kind_cur;
   logic                 is_rect;
   logic [ntd_pkg::NDIM_BITS-1:0] dims2;
   logic signed [FB-1:0] lo_x, hi_x, p_x, a_x, b_x;
   logic                 below, above;
   logic [FB-1:0]        diff_in;
   logic [DB-1:0]        term;
   logic [DB:0]          sum;
   logic [DB-1:0]        trait_dist;
   logic [DB-1:0]        max_base, max_in;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;

   function automatic logic [FB-1:0] abs_val(input logic signed [FB-1:0] v);
      abs_val = v < 0 ? FB'(-v) : FB'(v);
   endfunction

   assign wr_addr  = {req_slot, req_dim_sel};
   assign rd_addr  = {cmd.trait, cmd.dim};
   assign kind_cur = kind_mem[cmd.trait];
   assign is_rect  = kind_cur == ntd_pkg::KIND_RECTANGLE;
   assign dims2    = dims_num > 3'd2 ? 3'd2 : dims_num;

   always_comb begin
      status.kind_ok  = kind_cur <= ntd_pkg::KIND_HYPERBOX;
      status.rsp_busy = rsp_valid_ff && !rsp_ready;
      case (kind_cur)
         ntd_pkg::KIND_POINT, ntd_pkg::KIND_RECTANGLE: status.dims = dims2;
         ntd_pkg::KIND_INTERVAL: status.dims = 3'd1;
         default: status.dims = dims_num;
      endcase
   end

   // table writes and registered table reads
   always_ff @(posedge clock) begin
      if (cmd.write_trait) begin
         kind_mem[req_slot]  <= req_kind;
         color_mem[req_slot] <= req_color_index;
         low_mem[wr_addr]    <= req_bound_low;
         high_mem[wr_addr]   <= req_bound_high;
      end
      if (cmd.mem_read) begin
         low_rd_ff  <= low_mem[rd_addr];
         high_rd_ff <= high_mem[rd_addr];
      end
   end

   // per-dimension difference, saturating accumulation, trait distance and running maximum
   always_comb begin
      lo_x  = FB'(low_rd_ff);
      hi_x  = FB'(high_rd_ff);
      p_x   = FB'(sample_ff[cmd.dim]);
      a_x   = lo_x > hi_x ? hi_x : lo_x;
      b_x   = lo_x > hi_x ? lo_x : hi_x;
      below = p_x < a_x;
      above = p_x > b_x;
      case (kind_cur)
         ntd_pkg::KIND_POINT, ntd_pkg::KIND_NDPOINT: diff_in = abs_val(lo_x - p_x);
         ntd_pkg::KIND_RECTANGLE: diff_in = abs_val((p_x <<< 1) - lo_x - hi_x);
         default: begin
            if (below) diff_in = FB'(a_x - p_x);
            else if (above) diff_in = FB'(p_x - b_x);
            else diff_in = '0;
         end
      endcase
      term = is_rect ? sq_ff[DB+1:2] : sq_ff[DB-1:0];
      sum  = {1'b0, acc_ff} + {1'b0, term};
      acc_in = sum[DB] ? ntd_pkg::DIST_MAX : sum[DB-1:0];
      trait_dist = (is_rect && !trait_out_ff) ? '0 : acc_ff;
      max_base = sof_ff ? '0 : max_seen_ff;
      max_in   = best_ff > max_base ? best_ff : max_base;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff[0] <= req_sample_0;
         sample_ff[1] <= req_sample_1;
         sample_ff[2] <= req_sample_2;
         sample_ff[3] <= req_sample_3;
         sof_ff <= req_start_of_frame;
         best_ff <= ntd_pkg::DIST_MAX;
         best_slot_ff <= '0;
         best_color_ff <= '0;
      end
      if (cmd.eval) begin
         diff_ff <= diff_in;
         outside_ff <= below || above;
      end
      if (cmd.square) sq_ff <= diff_ff * diff_ff;
      if (cmd.trait_init) begin
         acc_ff <= '0;
         trait_out_ff <= 1'b0;
      end else if (cmd.accum) begin
         acc_ff <= acc_in;
         trait_out_ff <= trait_out_ff || outside_ff;
      end
      if (cmd.compare && (!found_ff || trait_dist < best_ff)) begin
         best_ff <= trait_dist;
         best_slot_ff <= cmd.trait;
         best_color_ff <= color_mem[cmd.trait];
      end
      if (cmd.finish) begin
         rsp_dist_ff  <= best_ff;
         rsp_slot_ff  <= best_slot_ff;
         rsp_color_ff <= best_color_ff;
         rsp_max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         max_seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_sample) found_ff <= 1'b0;
         else if (cmd.compare) found_ff <= 1'b1;
         if (cmd.finish) begin
            max_seen_ff <= max_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_min_distance  = rsp_dist_ff;
   assign rsp_nearest_slot  = rsp_slot_ff;
   assign rsp_nearest_color = rsp_color_ff;
   assign rsp_running_max   = rsp_max_ff;

endmodule

// ===== sv/ntd_controller.sv =====
`timescale 1ns / 1ps
// ntd_controller: sequencer over trait slots and dimensions
// depends on ntd_pkg; commands ntd_datapath
module ntd_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [ntd_pkg::COUNT_BITS-1:0]   trait_num,
   input  ntd_pkg::ntd_status_type          status,
   output ntd_pkg::ntd_cmd_type             cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_TRAIT   = 9'b000000010,
      ST_READ    = 9'b000000100,
      ST_EVAL    = 9'b000001000,
      ST_SQUARE  = 9'b000010000,
      ST_ACCUM   = 9'b000100000,
      ST_COMPARE = 9'b001000000,
      ST_NEXT    = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [ntd_pkg::SLOT_BITS-1:0] trait_ff, trait_in;
   logic [ntd_pkg::DIM_BITS-1:0]  dim_ff, dim_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      trait_in = trait_ff;
      dim_in   = dim_ff;
      cmd = '0;
      cmd.trait = trait_ff;
      cmd.dim   = dim_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == ntd_pkg::CMD_SAMPLE) begin
                  cmd.load_sample = 1'b1;
                  trait_in = '0;
                  state_in = ST_TRAIT;
               end else begin
                  cmd.write_trait = 1'b1;
               end
            end
         end
         ST_TRAIT: begin
            cmd.trait_init = 1'b1;
            dim_in = '0;
            state_in = status.kind_ok ? ST_READ : ST_NEXT;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if ({1'b0, dim_ff} + 3'd1 == status.dims) begin
               state_in = ST_COMPARE;
            end else begin
               dim_in = dim_ff + 2'd1;
               state_in = ST_READ;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if ({1'b0, trait_ff} + 5'd1 == trait_num) begin
               state_in = ST_DONE;
            end else begin
               trait_in = trait_ff + 4'd1;
               state_in = ST_TRAIT;
            end
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         trait_ff <= '0;
         dim_ff <= '0;
      end else begin
         state_ff <= state_in;
         trait_ff <= trait_in;
         dim_ff <= dim_in;
      end
   end

endmodule

// ===== sv/nearest_trait_distance.sv =====
`timescale 1ns / 1ps
// nearest_trait_distance: top level with configuration registers
// depends on ntd_pkg, ntd_controller, ntd_datapath
//
// A write word (cmd 0) loads one dimension of one trait slot. A sample word (cmd 1) is
// searched over slots 0..n-1, n being trait_count clamped to 1..16, by one shared distance
// unit that handles each dimension in turn (table read, difference, square, accumulate);
// traits of a kind above hyperbox are skipped. A finished result waits in the output
// register while the next word is taken.
module nearest_trait_distance (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic [ntd_pkg::SLOT_BITS-1:0]         req_slot,
   input  logic [2:0]                            req_kind,
   input  logic [7:0]                            req_color_index,
   input  logic [ntd_pkg::DIM_BITS-1:0]          req_dim_sel,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0] req_bound_low,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0] req_bound_high,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0] req_sample_0,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0] req_sample_1,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0] req_sample_2,
   input  logic signed [ntd_pkg::VALUE_BITS-1:0] req_sample_3,
   input  logic                                  req_start_of_frame,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ntd_pkg::DIST_BITS-1:0]         rsp_min_distance,
   output logic [ntd_pkg::SLOT_BITS-1:0]         rsp_nearest_slot,
   output logic [7:0]                            rsp_nearest_color,
   output logic [ntd_pkg::DIST_BITS-1:0]         rsp_running_max,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [2:0]                            paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   logic [ntd_pkg::COUNT_BITS-1:0] trait_count_ff;
   logic [ntd_pkg::NDIM_BITS-1:0]  dims_ff;
   logic [ntd_pkg::COUNT_BITS-1:0] trait_num;
   logic [ntd_pkg::NDIM_BITS-1:0]  dims_num;
   logic                           csr_write;
   ntd_pkg::ntd_cmd_type           cmd;
   ntd_pkg::ntd_status_type        status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         trait_count_ff <= 5'd1;
         dims_ff <= 3'd1;
      end else if (csr_write) begin
         unique case (paddr[2])
            ntd_pkg::REG_TRAIT_COUNT: trait_count_ff <= pwdata[ntd_pkg::COUNT_BITS-1:0];
            ntd_pkg::REG_DIMS_IN_USE: dims_ff <= pwdata[ntd_pkg::NDIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         ntd_pkg::REG_TRAIT_COUNT: prdata = {27'b0, trait_count_ff};
         ntd_pkg::REG_DIMS_IN_USE: prdata = {29'b0, dims_ff};
         default: prdata = '0;
      endcase
      if (trait_count_ff == '0) trait_num = 5'd1;
      else if (trait_count_ff > 5'(ntd_pkg::MAX_TRAITS)) trait_num = 5'(ntd_pkg::MAX_TRAITS);
      else trait_num = trait_count_ff;
      if (dims_ff == '0) dims_num = 3'd1;
      else if (dims_ff > 3'(ntd_pkg::MAX_DIMS)) dims_num = 3'(ntd_pkg::MAX_DIMS);
      else dims_num = dims_ff;
   end

   ntd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .trait_num (trait_num),
      .status    (status),
      .cmd       (cmd)
   );

   ntd_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .dims_num           (dims_num),
      .req_slot           (req_slot),
      .req_kind           (req_kind),
      .req_color_index    (req_color_index),
      .req_dim_sel        (req_dim_sel),
      .req_bound_low      (req_bound_low),
      .req_bound_high     (req_bound_high),
      .req_sample_0       (req_sample_0),
      .req_sample_1       (req_sample_1),
      .req_sample_2       (req_sample_2),
      .req_sample_3       (req_sample_3),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_min_distance   (rsp_min_distance),
      .rsp_nearest_slot   (rsp_nearest_slot),
      .rsp_nearest_color  (rsp_nearest_color),
      .rsp_running_max    (rsp_running_max)
   );

endmodule

// ===== sv/ntd_checker.sv =====
`timescale 1ns / 1ps
// ntd_checker: port-level checks of nearest_trait_distance, bound to the top level
// depends on ntd_pkg and the top-level ports
module ntd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [ntd_pkg::DIST_BITS-1:0]         rsp_min_distance,
   input logic [ntd_pkg::SLOT_BITS-1:0]         rsp_nearest_slot,
   input logic [ntd_pkg::DIST_BITS-1:0]         rsp_running_max
);

   // no word left over after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_distance)
         && $stable(rsp_running_max) && $stable(rsp_nearest_slot))
      else $error("stalled result word changed");

   // running max covers the current minimum
   a_max_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_running_max >= rsp_min_distance)
      else $error("running max below min distance");

   // no sample taken while the sequencer still works
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid || !req_ready)
      else $error("result and ready without sequencing");

endmodule

bind nearest_trait_distance ntd_checker u_ntd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_min_distance (rsp_min_distance),
   .rsp_nearest_slot (rsp_nearest_slot),
   .rsp_running_max  (rsp_running_max)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for nearest_trait_distance, trait table loads and sample searches
// depends on ntd_pkg and nearest_trait_distance; predicts each result in step with accepted words
module tb;

   localparam logic [2:0] ADDR_TRAIT_COUNT = 3'd0;
   localparam logic [2:0] ADDR_DIMS_IN_USE = 3'd4;
   localparam logic [2:0] KIND_SKIP_LOW    = 3'd5;
   localparam logic [2:0] KIND_SKIP_HIGH   = 3'd7;
   localparam logic signed [ntd_pkg::VALUE_BITS-1:0] VAL_MIN =
      {1'b1, {(ntd_pkg::VALUE_BITS-1){1'b0}}};
   localparam logic signed [ntd_pkg::VALUE_BITS-1:0] VAL_MAX =
      {1'b0, {(ntd_pkg::VALUE_BITS-1){1'b1}}};

   typedef struct {
      logic                                  cmd;
      logic [ntd_pkg::SLOT_BITS-1:0]         slot;
      logic [2:0]                            kind;
      logic [7:0]                            color;
      logic [ntd_pkg::DIM_BITS-1:0]          dim;
      logic signed [ntd_pkg::VALUE_BITS-1:0] lo;
      logic signed [ntd_pkg::VALUE_BITS-1:0] hi;
      logic signed [ntd_pkg::VALUE_BITS-1:0] s [4];
      logic                                  sof;
   } word_type;

   typedef struct packed {
      logic [ntd_pkg::DIST_BITS-1:0] min_dist;
      logic [ntd_pkg::SLOT_BITS-1:0] slot;
      logic [7:0]                    color;
      logic [ntd_pkg::DIST_BITS-1:0] maxv;
   } nearest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_cmd = 1'b0, req_start_of_frame = 1'b0;
   logic req_ready;
   logic [ntd_pkg::SLOT_BITS-1:0] req_slot = '0;
   logic [2:0] req_kind = '0;
   logic [7:0] req_color_index = '0;
   logic [ntd_pkg::DIM_BITS-1:0] req_dim_sel = '0;
   logic signed [ntd_pkg::VALUE_BITS-1:0] req_bound_low = '0, req_bound_high = '0;
   logic signed [ntd_pkg::VALUE_BITS-1:0] req_sample_0 = '0, req_sample_1 = '0;
   logic signed [ntd_pkg::VALUE_BITS-1:0] req_sample_2 = '0, req_sample_3 = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [ntd_pkg::DIST_BITS-1:0] rsp_min_distance, rsp_running_max;
   logic [ntd_pkg::SLOT_BITS-1:0] rsp_nearest_slot;
   logic [7:0] rsp_nearest_color;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;

   nearest_trait_distance u_dut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [2:0] kind_mem [ntd_pkg::MAX_TRAITS];
   logic [7:0] color_mem [ntd_pkg::MAX_TRAITS];
   logic signed [ntd_pkg::VALUE_BITS-1:0] low_mem [ntd_pkg::MAX_TRAITS*ntd_pkg::MAX_DIMS];
   logic signed [ntd_pkg::VALUE_BITS-1:0] high_mem [ntd_pkg::MAX_TRAITS*ntd_pkg::MAX_DIMS];
   logic [ntd_pkg::DIST_BITS-1:0] frame_max = '0;
   logic [ntd_pkg::COUNT_BITS-1:0] trait_count_reg = 5'd1;
   logic [ntd_pkg::NDIM_BITS-1:0] dims_reg = 3'd1;

   nearest_type nearest_q [$];
   int mismatches = 0;
   int burst_left = 0;
   int cyc = 0;

   function automatic longint sq_sat(longint d);
      if (d > 64'h1FFFFFF) return longint'(ntd_pkg::DIST_MAX);
      return d * d;
   endfunction

   function automatic longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      return (s > longint'(ntd_pkg::DIST_MAX)) ? longint'(ntd_pkg::DIST_MAX) : s;
   endfunction

   function automatic longint absd(longint a, longint b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic nearest_type search_traits(word_type w);
      nearest_type r;
      longint best, trait_dist, a, b, p, dd, q;
      int nt, nd, nd2, n;
      bit found, ins;
      best = longint'(ntd_pkg::DIST_MAX);
      found = 0;
      r = '0;
      nt = (trait_count_reg < 1) ? 1 : (trait_count_reg > ntd_pkg::MAX_TRAITS)
           ? ntd_pkg::MAX_TRAITS : trait_count_reg;
      nd = (dims_reg < 1) ? 1 : (dims_reg > ntd_pkg::MAX_DIMS) ? ntd_pkg::MAX_DIMS : dims_reg;
      nd2 = (nd < 2) ? nd : 2;
      for (int t = 0; t < nt; t++) begin
         if (kind_mem[t] > ntd_pkg::KIND_HYPERBOX) continue;
         trait_dist = 0;
         ins = 1;
         if (kind_mem[t] == ntd_pkg::KIND_POINT || kind_mem[t] == ntd_pkg::KIND_NDPOINT) begin
            n = (kind_mem[t] == ntd_pkg::KIND_POINT) ? nd2 : nd;
            for (int d = 0; d < n; d++)
               trait_dist = add_sat(trait_dist,
                                    sq_sat(absd(low_mem[t*ntd_pkg::MAX_DIMS+d], w.s[d])));
         end else begin
            n = (kind_mem[t] == ntd_pkg::KIND_INTERVAL) ? 1
                : (kind_mem[t] == ntd_pkg::KIND_RECTANGLE) ? nd2 : nd;
            for (int d = 0; d < n; d++) begin
               a = low_mem[t*ntd_pkg::MAX_DIMS+d];
               b = high_mem[t*ntd_pkg::MAX_DIMS+d];
               p = w.s[d];
               if (a > b) begin
                  q = a; a = b; b = q;
               end
               if (p < a) begin
                  ins = 0;
                  trait_dist = add_sat(trait_dist, sq_sat(a - p));
               end else if (p > b) begin
                  ins = 0;
                  trait_dist = add_sat(trait_dist, sq_sat(p - b));
               end
            end
            if (kind_mem[t] == ntd_pkg::KIND_RECTANGLE) begin
               trait_dist = 0;
               if (!ins)
                  for (int d = 0; d < n; d++) begin
                     dd = absd(2 * longint'(w.s[d]),
                               longint'(low_mem[t*ntd_pkg::MAX_DIMS+d])
                               + high_mem[t*ntd_pkg::MAX_DIMS+d]);
                     q = (dd > 64'h3FFFFFF) ? longint'(ntd_pkg::DIST_MAX) : (dd * dd) >>> 2;
                     trait_dist = add_sat(trait_dist, q);
                  end
            end
         end
         if (!found || trait_dist < best) begin
            found = 1;
            best = trait_dist;
            r.slot = ntd_pkg::SLOT_BITS'(t);
            r.color = color_mem[t];
         end
      end
      if (w.sof) frame_max = '0;
      if (best > longint'(frame_max)) frame_max = ntd_pkg::DIST_BITS'(best);
      r.min_dist = ntd_pkg::DIST_BITS'(best);
      r.maxv = frame_max;
      return r;
   endfunction

   task automatic send_word(word_type w);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd <= w.cmd;
      req_slot <= w.slot;
      req_kind <= w.kind;
      req_color_index <= w.color;
      req_dim_sel <= w.dim;
      req_bound_low <= w.lo;
      req_bound_high <= w.hi;
      req_sample_0 <= w.s[0];
      req_sample_1 <= w.s[1];
      req_sample_2 <= w.s[2];
      req_sample_3 <= w.s[3];
      req_start_of_frame <= w.sof;
      do @(posedge clock); while (!req_ready);
      if (w.cmd == ntd_pkg::CMD_WRITE) begin
         kind_mem[w.slot] = w.kind;
         color_mem[w.slot] = w.color;
         low_mem[w.slot*ntd_pkg::MAX_DIMS+w.dim] = w.lo;
         high_mem[w.slot*ntd_pkg::MAX_DIMS+w.dim] = w.hi;
      end else
         nearest_q.push_back(search_traits(w));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (nearest_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_TRAIT_COUNT) trait_count_reg = data[ntd_pkg::COUNT_BITS-1:0];
      else dims_reg = data[ntd_pkg::NDIM_BITS-1:0];
   endtask

   task automatic configure(int tc, int nd);
      drain();
      csr_write(ADDR_TRAIT_COUNT, tc);
      csr_write(ADDR_DIMS_IN_USE, nd);
   endtask

   function automatic logic signed [ntd_pkg::VALUE_BITS-1:0] rand_val();
      case ($urandom_range(0, 7))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2, 3: return $signed(ntd_pkg::VALUE_BITS'($urandom_range(0, 2000) - 1000));
         default: return $signed(ntd_pkg::VALUE_BITS'($urandom));
      endcase
   endfunction

   function automatic word_type trait_word(int slot, int kind, int dim,
                                           logic signed [ntd_pkg::VALUE_BITS-1:0] lo,
                                           logic signed [ntd_pkg::VALUE_BITS-1:0] hi);
      word_type w;
      w.cmd = ntd_pkg::CMD_WRITE; w.slot = ntd_pkg::SLOT_BITS'(slot); w.kind = 3'(kind);
      w.color = 8'($urandom);
      w.dim = ntd_pkg::DIM_BITS'(dim); w.lo = lo; w.hi = hi; w.sof = 1'($urandom);
      for (int d = 0; d < 4; d++) w.s[d] = rand_val();
      return w;
   endfunction

   function automatic word_type sample_word(logic signed [ntd_pkg::VALUE_BITS-1:0] a,
                                            logic signed [ntd_pkg::VALUE_BITS-1:0] b,
                                            logic signed [ntd_pkg::VALUE_BITS-1:0] c,
                                            logic signed [ntd_pkg::VALUE_BITS-1:0] e,
                                            logic sof);
      word_type w;
      w = trait_word($urandom, $urandom, $urandom, rand_val(), rand_val());
      w.cmd = ntd_pkg::CMD_SAMPLE; w.s[0] = a; w.s[1] = b; w.s[2] = c; w.s[3] = e;
      w.sof = sof;
      return w;
   endfunction

   // every entry is written before any search reads it
   task automatic test_table_load();
      for (int t = 0; t < ntd_pkg::MAX_TRAITS; t++)
         for (int d = 0; d < ntd_pkg::MAX_DIMS; d++)
            send_word(trait_word(t, t % 5, d,
               (t == 2) ? VAL_MAX : $signed(ntd_pkg::VALUE_BITS'(t * 1000 - 4000)),
               (t == 2) ? VAL_MIN : $signed(ntd_pkg::VALUE_BITS'(t * 1000 + 3000))));
   endtask

   task automatic test_directed();
      configure(16, 4);
      send_word(sample_word('0, '0, '0, '0, 1'b1));
      send_word(sample_word(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 1'b0));
      send_word(sample_word(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, 1'b0));
      send_word(sample_word(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, 1'b1));
      // rectangle hit inside, duplicate trait to check first wins on tie
      send_word(trait_word(5, ntd_pkg::KIND_RECTANGLE, 0, 100, -100));
      send_word(trait_word(5, ntd_pkg::KIND_RECTANGLE, 1, -100, 100));
      send_word(trait_word(6, ntd_pkg::KIND_RECTANGLE, 0, 100, -100));
      send_word(trait_word(6, ntd_pkg::KIND_RECTANGLE, 1, -100, 100));
      send_word(trait_word(15, KIND_SKIP_HIGH, 0, 0, 0));
      send_word(sample_word('0, '0, '0, '0, 1'b1));
      send_word(sample_word(VAL_MAX, VAL_MIN, 5, -5, 1'b0));
      configure(0, 0);
      send_word(sample_word(7, -7, 0, 0, 1'b0));
      configure(31, 7);
      send_word(sample_word(VAL_MIN, 3, VAL_MAX, 1, 1'b0));
      // no trait selected
      send_word(trait_word(0, KIND_SKIP_LOW, 0, 0, 0));
      configure(1, 2);
      send_word(sample_word(1, 2, 3, 4, 1'b0));
      send_word(sample_word(VAL_MAX, VAL_MAX, 0, 0, 1'b1));
   endtask

   task automatic test_random();
      int tc, nd;
      word_type w;
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: begin tc = 16; nd = 4; end
            1: begin tc = 1; nd = 1; end
            2: begin tc = 31; nd = 7; end
            default: begin tc = $urandom_range(0, 31); nd = $urandom_range(0, 7); end
         endcase
         configure(tc, nd);
         repeat (52) begin
            if ($urandom_range(0, 9) < 3) begin
               w = trait_word($urandom, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                              : $urandom_range(0, 4), $urandom, rand_val(), rand_val());
               send_word(w);
            end else
               send_word(sample_word(rand_val(), rand_val(), rand_val(), rand_val(),
                                     $urandom_range(0, 9) == 0));
         end
      end
   endtask

   // receiver stall pattern, cycling through four ready modes
   always @(posedge clock) begin
      cyc <= cyc + 1;
      case ((cyc / 1500) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (cyc % 8) == 0;
         default: rsp_ready <= (cyc % 200) > 120;
      endcase
   end

   always @(posedge clock) begin
      nearest_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (nearest_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word");
         end else begin
            e = nearest_q.pop_front();
            if (rsp_min_distance !== e.min_dist || rsp_nearest_slot !== e.slot ||
                rsp_nearest_color !== e.color || rsp_running_max !== e.maxv) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %h/%0d/%0d/%h got %h/%0d/%0d/%h",
                           e.min_dist, e.slot, e.color, e.maxv, rsp_min_distance,
                           rsp_nearest_slot, rsp_nearest_color, rsp_running_max);
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_table_load();
      test_directed();
      test_random();
      drain();
      if (mismatches == 0 && nearest_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #40ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/ntd_pkg.sv
sv/ntd_datapath.sv
sv/ntd_controller.sv
sv/nearest_trait_distance.sv
sv/ntd_checker.sv
tb/tb.sv
